// ===== rtl/lfu_ofc_pkg.sv =====
// Shared types for the least-used open-file cache: scan flags, slot write control, FSM states.
package lfu_ofc_pkg;

	localparam int TAG_W  = 16;
	localparam int SLOT_W = 3;

	// Flags that travel down the cell row with a lookup request
	typedef struct packed {
		logic active;     // a lookup request sits in this stage
		logic found;      // a valid slot upstream matched the tag
		logic free_found; // an invalid slot upstream was seen
		logic have_min;   // min fields hold a real candidate
	} scan_flags_t;

	// Broadcast write into one slot, chosen by index
	typedef struct packed {
		logic en;    // write this cycle
		logic bump;  // 1: saturating count increment, 0: load new tag
		logic valid; // valid bit written on a load
	} wr_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/lfu_ofc_cell.sv =====
// One cache slot: holds tag, valid and use count, and folds them into the passing lookup request.
module lfu_ofc_cell #(
	parameter int COUNT_BITS = 16,
	parameter int IDX_W      = 3,
	parameter int IDX        = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// lookup request from the upstream neighbor
	input  lfu_ofc_pkg::scan_flags_t         in_flags,
	input  logic [lfu_ofc_pkg::TAG_W-1:0]    in_tag,
	input  logic [IDX_W-1:0]                 in_hit_idx,
	input  logic [IDX_W-1:0]                 in_free_idx,
	input  logic [IDX_W-1:0]                 in_min_idx,
	input  logic [COUNT_BITS-1:0]            in_min_cnt,
	input  logic [lfu_ofc_pkg::TAG_W-1:0]    in_min_tag,
	// lookup request handed to the downstream neighbor
	output lfu_ofc_pkg::scan_flags_t         out_flags,
	output logic [lfu_ofc_pkg::TAG_W-1:0]    out_tag,
	output logic [IDX_W-1:0]                 out_hit_idx,
	output logic [IDX_W-1:0]                 out_free_idx,
	output logic [IDX_W-1:0]                 out_min_idx,
	output logic [COUNT_BITS-1:0]            out_min_cnt,
	output logic [lfu_ofc_pkg::TAG_W-1:0]    out_min_tag,
	// slot update
	input  lfu_ofc_pkg::wr_ctl_t             wr_ctl,
	input  logic [IDX_W-1:0]                 wr_idx,
	input  logic [lfu_ofc_pkg::TAG_W-1:0]    wr_tag
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [lfu_ofc_pkg::TAG_W-1:0] tag_q;
	logic                          valid_q;
	logic [COUNT_BITS-1:0]         count_q;

	lfu_ofc_pkg::scan_flags_t      flags_d;
	logic [IDX_W-1:0]              hit_idx_d;
	logic [IDX_W-1:0]              free_idx_d;
	logic [IDX_W-1:0]              min_idx_d;
	logic [COUNT_BITS-1:0]         min_cnt_d;
	logic [lfu_ofc_pkg::TAG_W-1:0] min_tag_d;
	logic                          take_min;
	logic                          wr_sel;

	// Fold this slot into the request: first match, first free, first smallest count
	always_comb begin
		flags_d    = in_flags;
		hit_idx_d  = in_hit_idx;
		free_idx_d = in_free_idx;
		min_idx_d  = in_min_idx;
		min_cnt_d  = in_min_cnt;
		min_tag_d  = in_min_tag;
		take_min   = !in_flags.have_min || (count_q < in_min_cnt);
		if (!in_flags.found && valid_q && (tag_q == in_tag)) begin
			flags_d.found = 1'b1;
			hit_idx_d     = MY_IDX;
		end
		if (!in_flags.free_found && !valid_q) begin
			flags_d.free_found = 1'b1;
			free_idx_d         = MY_IDX;
		end
		if (take_min) begin
			flags_d.have_min = 1'b1;
			min_idx_d        = MY_IDX;
			min_cnt_d        = count_q;
			min_tag_d        = tag_q;
		end
	end

	// Hand-off register to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_flags <= '0;
		end else begin
			out_flags <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		out_tag      <= in_tag;
		out_hit_idx  <= hit_idx_d;
		out_free_idx <= free_idx_d;
		out_min_idx  <= min_idx_d;
		out_min_cnt  <= min_cnt_d;
		out_min_tag  <= min_tag_d;
	end

	assign wr_sel = wr_ctl.en && (wr_idx == MY_IDX);

	// Slot state: valid and count cleared at reset, tag left as is
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else if (wr_sel) begin
			if (wr_ctl.bump) begin
				if (count_q != {COUNT_BITS{1'b1}}) count_q <= count_q + COUNT_BITS'(1);
			end else begin
				valid_q <= wr_ctl.valid;
				count_q <= COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel && !wr_ctl.bump) tag_q <= wr_tag;
	end

endmodule

// ===== rtl/lfu_open_file_cache.sv =====
// Top level of the least-used open-file cache: request control, cell row, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------------
//  request  | in_valid / in_ready  | font_tag, open_ok
//  result   | out_valid/ out_ready | repeat_res, hit, slot, evicted, evicted_tag, loaded
//
// A lookup walks the row of SLOTS cells, one cell per cycle; the final step then writes
// the chosen slot and loads the result register. A repeat of the previous request skips
// the walk and the write and only loads the result register.
// One request is in flight at a time; a new one is taken while the last result waits.
// A stalled result holds the block in its final step until out_ready frees the register.
// Reset clears all valid bits and use counts at once; no clearing pass.
module lfu_open_file_cache #(
	parameter int SLOTS      = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [lfu_ofc_pkg::TAG_W-1:0]         font_tag,
	input  logic                                  open_ok,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  repeat_res,
	output logic                                  hit,
	output logic [lfu_ofc_pkg::SLOT_W-1:0]        slot,
	output logic                                  evicted,
	output logic [lfu_ofc_pkg::TAG_W-1:0]         evicted_tag,
	output logic                                  loaded
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	lfu_ofc_pkg::state_t state_q, state_d;

	// chain taps, index 0 is the row input
	lfu_ofc_pkg::scan_flags_t          c_flags    [0:SLOTS];
	logic [lfu_ofc_pkg::TAG_W-1:0]     c_tag      [0:SLOTS];
	logic [IDX_W-1:0]                  c_hit_idx  [0:SLOTS];
	logic [IDX_W-1:0]                  c_free_idx [0:SLOTS];
	logic [IDX_W-1:0]                  c_min_idx  [0:SLOTS];
	logic [COUNT_BITS-1:0]             c_min_cnt  [0:SLOTS];
	logic [lfu_ofc_pkg::TAG_W-1:0]     c_min_tag  [0:SLOTS];

	logic                              accept;
	logic                              is_rep;
	logic                              start;
	logic                              scan_done;
	logic                              out_load;
	lfu_ofc_pkg::wr_ctl_t              wr_ctl;

	logic [lfu_ofc_pkg::TAG_W-1:0]     last_tag_q;
	logic                              last_valid_q;
	logic [lfu_ofc_pkg::TAG_W-1:0]     req_tag_q;
	logic                              ok_q;

	logic                              rep_q;
	logic                              found_q;
	logic [IDX_W-1:0]                  pick_q;
	logic                              ev_q;
	logic [lfu_ofc_pkg::TAG_W-1:0]     ev_tag_q;

	logic                              out_valid_q;
	logic                              repeat_res_q;
	logic                              hit_q;
	logic [lfu_ofc_pkg::SLOT_W-1:0]    slot_q;
	logic                              evicted_q;
	logic [lfu_ofc_pkg::TAG_W-1:0]     evicted_tag_q;
	logic                              loaded_q;

	assign accept    = in_valid && in_ready;
	assign is_rep    = last_valid_q && (last_tag_q == font_tag);
	assign scan_done = c_flags[SLOTS].active;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lfu_ofc_pkg::ST_IDLE: begin
				if (accept) state_d = is_rep ? lfu_ofc_pkg::ST_DONE : lfu_ofc_pkg::ST_SCAN;
			end
			lfu_ofc_pkg::ST_SCAN: begin
				if (scan_done) state_d = lfu_ofc_pkg::ST_DONE;
			end
			lfu_ofc_pkg::ST_DONE: begin
				if (out_load) state_d = lfu_ofc_pkg::ST_IDLE;
			end
			default: state_d = lfu_ofc_pkg::ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_ready     = 1'b0;
		out_load     = 1'b0;
		start        = 1'b0;
		wr_ctl       = '0;
		case (state_q)
			lfu_ofc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				start    = in_valid && !is_rep;
			end
			lfu_ofc_pkg::ST_SCAN: begin
			end
			lfu_ofc_pkg::ST_DONE: begin
				out_load     = !out_valid_q || out_ready;
				wr_ctl.en    = out_load && !rep_q;
				wr_ctl.bump  = found_q;
				wr_ctl.valid = ok_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_ofc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Previous request, for repeat detection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tag_q   <= '0;
			last_valid_q <= 1'b0;
		end else if (accept && !is_rep) begin
			last_tag_q   <= font_tag;
			last_valid_q <= 1'b1;
		end
	end

	// Row input
	always_comb begin
		c_flags[0]        = '0;
		c_flags[0].active = start;
		c_tag[0]          = font_tag;
		c_hit_idx[0]      = '0;
		c_free_idx[0]     = '0;
		c_min_idx[0]      = '0;
		c_min_cnt[0]      = '0;
		c_min_tag[0]      = '0;
	end

	// Row of slot cells
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		lfu_ofc_cell #(
			.COUNT_BITS (COUNT_BITS),
			.IDX_W      (IDX_W),
			.IDX        (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.in_flags     (c_flags[i]),
			.in_tag       (c_tag[i]),
			.in_hit_idx   (c_hit_idx[i]),
			.in_free_idx  (c_free_idx[i]),
			.in_min_idx   (c_min_idx[i]),
			.in_min_cnt   (c_min_cnt[i]),
			.in_min_tag   (c_min_tag[i]),
			.out_flags    (c_flags[i+1]),
			.out_tag      (c_tag[i+1]),
			.out_hit_idx  (c_hit_idx[i+1]),
			.out_free_idx (c_free_idx[i+1]),
			.out_min_idx  (c_min_idx[i+1]),
			.out_min_cnt  (c_min_cnt[i+1]),
			.out_min_tag  (c_min_tag[i+1]),
			.wr_ctl       (wr_ctl),
			.wr_idx       (pick_q),
			.wr_tag       (req_tag_q)
		);
	end

	// Request and decision registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_tag_q <= font_tag;
			ok_q      <= open_ok;
			rep_q     <= is_rep;
			found_q   <= 1'b0;
			pick_q    <= '0;
			ev_q      <= 1'b0;
			ev_tag_q  <= '0;
		end else if (state_q == lfu_ofc_pkg::ST_SCAN && scan_done) begin
			found_q <= c_flags[SLOTS].found;
			if (c_flags[SLOTS].found) begin
				pick_q <= c_hit_idx[SLOTS];
			end else if (c_flags[SLOTS].free_found) begin
				pick_q <= c_free_idx[SLOTS];
			end else begin
				pick_q   <= c_min_idx[SLOTS];
				ev_q     <= 1'b1;
				ev_tag_q <= c_min_tag[SLOTS];
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			repeat_res_q  <= rep_q;
			hit_q         <= !rep_q && found_q;
			slot_q        <= lfu_ofc_pkg::SLOT_W'(pick_q);
			evicted_q     <= ev_q;
			evicted_tag_q <= ev_tag_q;
			loaded_q      <= !rep_q && (found_q || ok_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign repeat_res  = repeat_res_q;
	assign hit         = hit_q;
	assign slot        = slot_q;
	assign evicted     = evicted_q;
	assign evicted_tag = evicted_tag_q;
	assign loaded      = loaded_q;

endmodule

// ===== rtl/lfu_ofc_checker.sv =====
// Port-level checks on the open-file cache results, bound to the top level.
module lfu_ofc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               repeat_res,
	input logic                               hit,
	input logic [lfu_ofc_pkg::SLOT_W-1:0]     slot,
	input logic                               evicted,
	input logic [lfu_ofc_pkg::TAG_W-1:0]      evicted_tag,
	input logic                               loaded
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(evicted_tag))
		else $error("result changed while stalled");

	// a repeat reports nothing else
	a_repeat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && repeat_res |-> !hit && !evicted && !loaded && slot == '0
			&& evicted_tag == '0)
		else $error("repeat result carries other fields");

	// a hit is loaded and never evicts
	a_hit_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> loaded && !evicted)
		else $error("hit without load or with eviction");

	// no eviction, no evicted tag
	a_no_ev_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted |-> evicted_tag == '0)
		else $error("evicted tag without eviction");

endmodule

bind lfu_open_file_cache lfu_ofc_checker u_lfu_ofc_checker (.*);

// ===== verif/lfu_open_file_cache_chk.sv =====
`timescale 1ns / 1ps
// Request/result monitor for the least-used open-file cache: predicts every result and compares.
module lfu_open_file_cache_chk #(
	parameter int SLOTS      = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [lfu_ofc_pkg::TAG_W-1:0]  font_tag,
	input  logic                           open_ok,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           repeat_res,
	input  logic                           hit,
	input  logic [lfu_ofc_pkg::SLOT_W-1:0] slot,
	input  logic                           evicted,
	input  logic [lfu_ofc_pkg::TAG_W-1:0]  evicted_tag,
	input  logic                           loaded,
	output int                             mismatches,
	output int                             pending
);
	localparam int TAG_W  = lfu_ofc_pkg::TAG_W;
	localparam int SLOT_W = lfu_ofc_pkg::SLOT_W;

	typedef struct packed {
		logic              repeat_res;
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
		logic [TAG_W-1:0]  evicted_tag;
		logic              loaded;
	} lookup_res_t;

	// shadow copy of the cache contents
	logic [TAG_W-1:0]      slot_tag  [SLOTS];
	logic                  slot_live [SLOTS];
	logic [COUNT_BITS-1:0] slot_uses [SLOTS];
	logic [TAG_W-1:0]      prev_tag;
	logic                  prev_live;

	lookup_res_t lookup_res_q [$];
	int          results_seen;

	// one line per bad result
	task automatic report_mismatch(input string msg);
		$display("%0t lfu_chk: %s", $time, msg);
		mismatches++;
	endtask

	function automatic string fmt_res(input lookup_res_t r);
		return $sformatf("rep=%0b hit=%0b slot=%0d ev=%0b ev_tag=%h ld=%0b",
			r.repeat_res, r.hit, r.slot, r.evicted, r.evicted_tag, r.loaded);
	endfunction

	// apply one request to the shadow cache and return what the block should answer
	function automatic lookup_res_t lookup_font(input logic [TAG_W-1:0] t, input logic ok);
		lookup_res_t r;
		int          i;
		int          pick;
		bit          found;
		bit          free_found;
		r = '0;
		pick = 0;
		found = 1'b0;
		free_found = 1'b0;

		// same tag as the previous request: skipped, nothing changes
		if (prev_live && prev_tag == t) begin
			r.repeat_res = 1'b1;
			return r;
		end

		for (i = 0; i < SLOTS; i++) begin
			if (!found && slot_live[i] && slot_tag[i] == t) begin
				pick = i;
				found = 1'b1;
			end
		end

		if (found) begin
			r.hit = 1'b1;
			r.loaded = 1'b1;
			if (slot_uses[pick] != {COUNT_BITS{1'b1}})
				slot_uses[pick] = slot_uses[pick] + 1'b1;
		end else begin
			for (i = 0; i < SLOTS; i++) begin
				if (!free_found && !slot_live[i]) begin
					pick = i;
					free_found = 1'b1;
				end
			end
			// cache full: first slot with the smallest count goes
			if (!free_found) begin
				pick = 0;
				for (i = 1; i < SLOTS; i++)
					if (slot_uses[i] < slot_uses[pick])
						pick = i;
				r.evicted = 1'b1;
				r.evicted_tag = slot_tag[pick];
			end
			slot_tag[pick] = t;
			slot_live[pick] = ok;
			slot_uses[pick] = COUNT_BITS'(1);
			r.loaded = ok;
		end

		prev_tag = t;
		prev_live = 1'b1;
		r.slot = pick[SLOT_W-1:0];
		return r;
	endfunction

	// compare the result on the bus with the oldest prediction
	task automatic check_result();
		lookup_res_t got;
		lookup_res_t want;
		string       bad;
		got.repeat_res = repeat_res;
		got.hit = hit;
		got.slot = slot;
		got.evicted = evicted;
		got.evicted_tag = evicted_tag;
		got.loaded = loaded;
		results_seen++;
		if (lookup_res_q.size() == 0) begin
			report_mismatch($sformatf("result %0d with no request pending: %s",
				results_seen, fmt_res(got)));
			return;
		end
		want = lookup_res_q.pop_front();
		bad = "";
		if (got.repeat_res !== want.repeat_res) bad = {bad, " repeat_res"};
		if (got.hit !== want.hit) bad = {bad, " hit"};
		if (got.slot !== want.slot) bad = {bad, " slot"};
		if (got.evicted !== want.evicted) bad = {bad, " evicted"};
		if (got.evicted_tag !== want.evicted_tag) bad = {bad, " evicted_tag"};
		if (got.loaded !== want.loaded) bad = {bad, " loaded"};
		if (bad != "")
			report_mismatch($sformatf("result %0d wrong%s: want %s got %s",
				results_seen, bad, fmt_res(want), fmt_res(got)));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_tag[i] = '0;
				slot_live[i] = 1'b0;
				slot_uses[i] = '0;
			end
			prev_tag = '0;
			prev_live = 1'b0;
			lookup_res_q.delete();
			results_seen = 0;
			mismatches = 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				lookup_res_q.push_back(lookup_font(font_tag, open_ok));
			if (out_valid && out_ready)
				check_result();
			pending <= lookup_res_q.size();
		end
	end

endmodule

// ===== verif/lfu_open_file_cache_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the least-used open-file cache: clock, reset, request stimulus and verdict.
module lfu_open_file_cache_tb;

	localparam int TAG_W      = lfu_ofc_pkg::TAG_W;
	localparam int SLOT_W     = lfu_ofc_pkg::SLOT_W;
	localparam int SLOTS      = 8;
	localparam int COUNT_BITS = 16;
	localparam int POOL_N     = 12;
	localparam int RAND_REQS  = 1500;
	localparam int HOT_ROUNDS = 64;
	localparam logic [TAG_W-1:0] HOT_A = 16'hC3A5;
	localparam logic [TAG_W-1:0] HOT_B = 16'h3C5A;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [TAG_W-1:0]  font_tag = '0;
	logic              open_ok = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              repeat_res;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic              evicted;
	logic [TAG_W-1:0]  evicted_tag;
	logic              loaded;

	int               mismatches;
	int               pending;
	bit               idle_on = 1'b0;
	int               ready_hold = 0;
	logic [TAG_W-1:0] last_sent = '0;
	logic [TAG_W-1:0] tag_pool [POOL_N];

	lfu_open_file_cache #(
		.SLOTS(SLOTS),
		.COUNT_BITS(COUNT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.font_tag(font_tag),
		.open_ok(open_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.repeat_res(repeat_res),
		.hit(hit),
		.slot(slot),
		.evicted(evicted),
		.evicted_tag(evicted_tag),
		.loaded(loaded)
	);

	lfu_open_file_cache_chk #(
		.SLOTS(SLOTS),
		.COUNT_BITS(COUNT_BITS)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.font_tag(font_tag),
		.open_ok(open_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.repeat_res(repeat_res),
		.hit(hit),
		.slot(slot),
		.evicted(evicted),
		.evicted_tag(evicted_tag),
		.loaded(loaded),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side: random stall bursts on out_ready while idling is on
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			ready_hold <= $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// present one request, optionally after a short gap, and wait until it is taken
	task automatic send_lookup(input logic [TAG_W-1:0] t, input logic ok);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		font_tag <= t;
		open_ok <= ok;
		last_sent = t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// mostly a small working set bigger than the cache, plus repeats and wild tags
	function automatic logic [TAG_W-1:0] random_tag();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return last_sent;
		if (roll < 25)
			return TAG_W'($urandom);
		if (roll < 30)
			tag_pool[$urandom_range(0, POOL_N - 1)] = TAG_W'($urandom);
		if (roll < 65)
			return tag_pool[$urandom_range(0, 3)];
		return tag_pool[$urandom_range(0, POOL_N - 1)];
	endfunction

	initial begin
		int n;
		for (n = 0; n < POOL_N; n++)
			tag_pool[n] = TAG_W'($urandom);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		// tag zero before any request is a miss, then a repeat ignores open_ok
		send_lookup(16'h0000, 1'b1);
		send_lookup(16'h0000, 1'b0);
		// failed open leaves slot 1 empty, a hit, then slot 1 reused
		send_lookup(16'hFFFF, 1'b0);
		send_lookup(16'h0000, 1'b1);
		send_lookup(16'hFFFF, 1'b1);
		send_lookup(16'hFFFF, 1'b1);
		// fill the rest of the cache
		send_lookup(16'h5555, 1'b1);
		send_lookup(16'hAAAA, 1'b1);
		send_lookup(16'h1234, 1'b1);
		send_lookup(16'h8000, 1'b1);
		send_lookup(16'h7FFF, 1'b1);
		send_lookup(16'h0001, 1'b1);
		// full: tie on the lowest count evicts the first such slot
		send_lookup(16'h00FF, 1'b1);
		send_lookup(16'h5555, 1'b1);
		// eviction made for a failed open, then the freed slot refilled
		send_lookup(16'h0F0F, 1'b0);
		send_lookup(16'hF0F0, 1'b1);
		send_lookup(16'h0F0F, 1'b1);
		send_lookup(16'h0000, 1'b1);
		send_lookup(16'hFFFF, 1'b0);

		// random traffic, idling switched on and off in stretches
		for (n = 0; n < RAND_REQS; n++) begin
			if (n % 100 == 0)
				idle_on = ($urandom_range(0, 2) != 0);
			send_lookup(random_tag(), $urandom_range(0, 7) != 0);
		end

		// back to back hits on two tags build large counts, then misses
		// that must evict the colder slots
		idle_on = 1'b0;
		for (n = 0; n < HOT_ROUNDS; n++) begin
			send_lookup(HOT_A, 1'b1);
			send_lookup(HOT_B, 1'b1);
		end
		for (n = 0; n < 40; n++)
			send_lookup(TAG_W'($urandom), 1'b1);
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4 * SLOTS) @(posedge clk);
		if (mismatches == 0)
			$display("lfu_open_file_cache_tb: clean");
		else
			$display("lfu_open_file_cache_tb: errors");
		$finish;
	end

	// hang guard, well above the slowest legal run
	initial begin
		#100_000_000;
		$display("lfu_open_file_cache_tb: errors");
		$finish;
	end

endmodule
